/* hdl/gbnms_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package gbnms_pkg;

    localparam int unsigned MAX_KEPT   = 256;
    localparam int unsigned COORD_BITS = 16;

    localparam int unsigned ADDR_W  = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int unsigned CNT_W   = $clog2(MAX_KEPT + 1);
    localparam int unsigned BOX_W   = 4 * COORD_BITS;
    localparam int unsigned AREA_W  = 2 * COORD_BITS;
    localparam int unsigned UNI_W   = AREA_W + 1;
    localparam int unsigned Q_W     = 17;
    localparam int unsigned MUL_A_W = UNI_W;
    localparam int unsigned MUL_B_W = (COORD_BITS > Q_W) ? COORD_BITS : Q_W;
    localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

    localparam logic [Q_W-1:0] ONE_Q16   = 17'd65536;
    localparam logic [Q_W-1:0] HALF_Q16  = 17'd32768;
    localparam logic [Q_W-1:0] THR_RESET = 17'd29491;
    localparam logic [Q_W-1:0] ETA_RESET = 17'd65536;

    typedef enum logic [7:0] {
        REG_NMS_THRESHOLD = 8'd0,
        REG_ETA           = 8'd1
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CDIM,
        S_CMUL,
        S_CAREA,
        S_RD,
        S_OVL,
        S_MI,
        S_MK,
        S_SUM,
        S_MU,
        S_CHK,
        S_DEC,
        S_DECAY
    } t_state;

endpackage

`default_nettype wire

/* hdl/greedy_box_nms.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  request when        payload
// s_axis    in   tvalid & tready     tdata: index, x_min, y_min, x_max, y_max; tlast: last
// m_axis    out  tvalid & tready     tdata: box_index; tuser: keep, list_full; tlast: done
// cfg       in   valid & ready       index: register, data: 17-bit Q1.16 value
//
// A request runs S_CDIM, S_CMUL and S_CAREA, then S_RD to S_CHK per kept box compared up
// to and including the first suppressing one, then S_DEC, plus S_DECAY when the threshold
// decays. Each compare walks the kept-box RAM read port and the shared multiplier: overlap,
// kept area, union * thr. Reset clears no RAM; entries at or above the count are never
// read. A finished result waits in the output register; the next request completes its
// compare loop and stalls only at decision while that register is still full.

module greedy_box_nms
    import gbnms_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [79:0] i_s_axis_tdata,  // prior_index, x_min, y_min, x_max, y_max
    input  wire logic        i_s_axis_tlast,  // last_in_class
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic      [15:0] o_m_axis_tdata,  // box_index
    output logic      [1:0]  o_m_axis_tuser,  // keep, list_full
    output logic             o_m_axis_tlast,  // class_done
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_index,
    input  wire logic [16:0] i_cfg_data
);

    localparam int unsigned CB = COORD_BITS;

    function automatic logic signed [CB-1:0] coord_of(input logic [15:0] raw);
        logic [CB+15:0] ext;
        ext = {{CB{1'b0}}, raw};
        return $signed(ext[CB-1:0]);
    endfunction

    // {h, w}, both zero unless both sides are positive
    function automatic logic [2*CB-1:0] dims_of(input logic signed [CB-1:0] x0,
                                                input logic signed [CB-1:0] y0,
                                                input logic signed [CB-1:0] x1,
                                                input logic signed [CB-1:0] y1);
        logic signed [CB:0] sw;
        logic signed [CB:0] sh;
        sw = {x1[CB-1], x1} - {x0[CB-1], x0};
        sh = {y1[CB-1], y1} - {y0[CB-1], y0};
        if (sw > 0 && sh > 0) begin
            return {sh[CB-1:0], sw[CB-1:0]};
        end
        return '0;
    endfunction

    t_state r_state, n_state;

    logic [Q_W-1:0]  r_nms_thr, r_eta, r_thr;
    logic [CNT_W-1:0] r_count, r_k;
    logic            r_keep, r_last, r_ovalid;
    logic [15:0]     r_index;
    logic signed [CB-1:0] r_cx0, r_cy0, r_cx1, r_cy1;
    logic [CB-1:0]   r_ow, r_oh, r_kw, r_kh;
    logic [AREA_W-1:0] r_carea, r_inter;
    logic [UNI_W-1:0]  r_uni;
    logic [15:0]     r_out_index;
    logic [1:0]      r_out_user;
    logic            r_out_last;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  mul_p;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [BOX_W-1:0]   ram_rdata;
    logic               in_req, out_free, full, keep_out, decay, suppress;
    logic [CNT_W-1:0]   k_next;
    logic signed [CB-1:0] kx0, ky0, kx1, ky1;
    logic signed [CB-1:0] ox0, oy0, ox1, oy1;

    assign in_req   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_ovalid || i_m_axis_tready;
    assign full     = r_keep && (r_count == CNT_W'(MAX_KEPT));
    assign keep_out = r_keep && !full;
    assign decay    = keep_out && (r_eta < ONE_Q16) && (r_thr > HALF_Q16);
    assign suppress = PROD_W'({r_inter, 16'b0}) > mul_p;
    assign k_next   = r_k + CNT_W'(1);

    assign kx0 = $signed(ram_rdata[CB-1:0]);
    assign ky0 = $signed(ram_rdata[2*CB-1:CB]);
    assign kx1 = $signed(ram_rdata[3*CB-1:2*CB]);
    assign ky1 = $signed(ram_rdata[4*CB-1:3*CB]);
    assign ox0 = (r_cx0 > kx0) ? r_cx0 : kx0;
    assign oy0 = (r_cy0 > ky0) ? r_cy0 : ky0;
    assign ox1 = (r_cx1 < kx1) ? r_cx1 : kx1;
    assign oy1 = (r_cy1 < ky1) ? r_cy1 : ky1;

    gbnms_ram #(
        .WIDTH (BOX_W),
        .DEPTH (MAX_KEPT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata ({r_cy1, r_cx1, r_cy0, r_cx0}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    gbnms_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_req) n_state = S_CDIM;
            S_CDIM:  n_state = S_CMUL;
            S_CMUL:  n_state = S_CAREA;
            S_CAREA: n_state = (r_count == '0) ? S_DEC : S_RD;
            S_RD:    n_state = S_OVL;
            S_OVL:   n_state = S_MI;
            S_MI:    n_state = S_MK;
            S_MK:    n_state = S_SUM;
            S_SUM:   n_state = S_MU;
            S_MU:    n_state = S_CHK;
            S_CHK: begin
                if (suppress || k_next == r_count) begin
                    n_state = S_DEC;
                end else begin
                    n_state = S_RD;
                end
            end
            S_DEC: begin
                if (out_free) begin
                    n_state = (decay && !r_last) ? S_DECAY : S_IDLE;
                end
            end
            S_DECAY: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        mul_a     = '0;
        mul_b     = '0;
        ram_we    = 1'b0;
        ram_raddr = r_k[ADDR_W-1:0];
        case (r_state)
            S_CMUL, S_MI: begin
                mul_a = MUL_A_W'(r_ow);
                mul_b = MUL_B_W'(r_oh);
            end
            S_MK: begin
                mul_a = MUL_A_W'(r_kw);
                mul_b = MUL_B_W'(r_kh);
            end
            S_MU: begin
                mul_a = r_uni;
                mul_b = MUL_B_W'(r_thr);
            end
            S_DEC: begin
                mul_a  = MUL_A_W'(r_thr);
                mul_b  = MUL_B_W'(r_eta);
                ram_we = out_free && keep_out;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_nms_thr <= THR_RESET;
            r_eta     <= ETA_RESET;
            r_thr     <= THR_RESET;
            r_count   <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_NMS_THRESHOLD: r_nms_thr <= i_cfg_data;
                    REG_ETA:           r_eta     <= i_cfg_data;
                    default: ;
                endcase
            end

            if (in_req && r_count == '0) begin
                r_thr <= r_nms_thr;
            end

            if (r_state == S_DEC && out_free) begin
                r_ovalid <= 1'b1;
                if (r_last) begin
                    r_count <= '0;
                    r_thr   <= r_nms_thr;
                end else if (keep_out) begin
                    r_count <= r_count + CNT_W'(1);
                end
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end

            if (r_state == S_DECAY) begin
                r_thr <= mul_p[16+Q_W-1:16];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_index <= i_s_axis_tdata[15:0];
                r_cx0   <= coord_of(i_s_axis_tdata[31:16]);
                r_cy0   <= coord_of(i_s_axis_tdata[47:32]);
                r_cx1   <= coord_of(i_s_axis_tdata[63:48]);
                r_cy1   <= coord_of(i_s_axis_tdata[79:64]);
                r_last  <= i_s_axis_tlast;
                r_keep  <= 1'b1;
                r_k     <= '0;
            end
            S_CDIM:  {r_oh, r_ow} <= dims_of(r_cx0, r_cy0, r_cx1, r_cy1);
            S_CAREA: r_carea <= mul_p[AREA_W-1:0];
            S_OVL: begin
                {r_oh, r_ow} <= dims_of(ox0, oy0, ox1, oy1);
                {r_kh, r_kw} <= dims_of(kx0, ky0, kx1, ky1);
            end
            S_MK:  r_inter <= mul_p[AREA_W-1:0];
            S_SUM: r_uni <= UNI_W'(r_carea) + UNI_W'(mul_p[AREA_W-1:0]) - UNI_W'(r_inter);
            S_CHK: begin
                if (suppress) begin
                    r_keep <= 1'b0;
                end
                r_k <= k_next;
            end
            S_DEC: begin
                if (out_free) begin
                    r_out_index <= r_index;
                    r_out_user  <= {full, keep_out};
                    r_out_last  <= r_last;
                end
            end
            default: ;
        endcase
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_out_index;
    assign o_m_axis_tuser  = r_out_user;
    assign o_m_axis_tlast  = r_out_last;
    assign o_cfg_ready     = 1'b1;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_KEPT))
        else $error("kept count above capacity");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tuser[0] && o_m_axis_tuser[1]))
        else $error("keep and list_full both set");

    a_class_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEC && out_free && r_last) |=> (r_count == '0 && r_thr == r_nms_thr))
        else $error("class end did not clear list");

    a_keep_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEC && out_free && keep_out && !r_last)
        |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("kept box not counted");

endmodule

`default_nettype wire

/* hdl/gbnms_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module gbnms_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 256,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* hdl/gbnms_mul.sv */
`timescale 1ns / 1ps
`default_nettype none

module gbnms_mul
    import gbnms_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic [MUL_A_W-1:0] i_a,
    input  wire logic [MUL_B_W-1:0] i_b,
    output logic      [PROD_W-1:0]  o_p
);

    always_ff @(posedge i_clk) begin
        o_p <= PROD_W'(i_a) * PROD_W'(i_b);
    end

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import gbnms_pkg::*;

    typedef struct {
        logic [15:0]        prior;
        logic signed [15:0] x0;
        logic signed [15:0] y0;
        logic signed [15:0] x1;
        logic signed [15:0] y1;
        logic               last;
    } t_cand;

    typedef struct {
        logic [15:0] box_index;
        logic        keep;
        logic        list_full;
        logic        class_done;
    } t_verdict;

    typedef struct {
        longint x0;
        longint y0;
        longint x1;
        longint y1;
    } t_corners;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [79:0] s_tdata   = '0;
    logic        s_tlast   = 1'b0;
    logic        m_tready  = 1'b1;
    logic        cfg_valid = 1'b0;
    logic [7:0]  cfg_index = '0;
    logic [16:0] cfg_data  = '0;

    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [15:0] o_m_axis_tdata;
    logic [1:0]  o_m_axis_tuser;
    logic        o_m_axis_tlast;
    logic        o_cfg_ready;

    greedy_box_nms DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    t_corners    kept_list[$];
    logic [16:0] thr_reg  = THR_RESET;
    logic [16:0] eta_reg  = ETA_RESET;
    logic [16:0] live_thr = THR_RESET;

    t_cand    box_stream_q[$];
    t_verdict verdict_q[$];
    t_cand    sent_cand;

    logic req_taken = 1'b0;
    logic res_taken = 1'b0;
    int   send_gap  = 0;
    int   recv_wait = 0;
    bit   send_calm = 1'b0;
    bit   recv_calm = 1'b0;

    int fail_count = 0;
    int n_boxes    = 0;
    int n_results  = 0;
    int n_writes   = 0;
    int n_kept     = 0;
    int n_supp     = 0;
    int n_full     = 0;
    int n_classes  = 0;

    function automatic longint unsigned rect_area(input longint x0, input longint y0,
                                                  input longint x1, input longint y1);
        longint w;
        longint h;
        w = x1 - x0;
        h = y1 - y0;
        if (w > 0 && h > 0) return w * h;
        return 0;
    endfunction

    function automatic bit overlap_too_big(input t_corners a, input t_corners b,
                                           input logic [16:0] thr);
        longint unsigned inter;
        longint unsigned uni;
        if (b.x0 > a.x1 || b.x1 < a.x0 || b.y0 > a.y1 || b.y1 < a.y0) return 1'b0;
        inter = rect_area(a.x0 > b.x0 ? a.x0 : b.x0, a.y0 > b.y0 ? a.y0 : b.y0,
                          a.x1 < b.x1 ? a.x1 : b.x1, a.y1 < b.y1 ? a.y1 : b.y1);
        if (inter == 0) return 1'b0;
        uni = rect_area(a.x0, a.y0, a.x1, a.y1) + rect_area(b.x0, b.y0, b.x1, b.y1) - inter;
        return (inter << 16) > uni * thr;
    endfunction

    function automatic t_verdict judge_candidate(input t_cand c);
        t_corners box;
        t_verdict v;
        bit       survive;
        survive = 1'b1;
        if (kept_list.size() == 0) live_thr = thr_reg;
        box.x0 = longint'(c.x0);
        box.y0 = longint'(c.y0);
        box.x1 = longint'(c.x1);
        box.y1 = longint'(c.y1);
        foreach (kept_list[k])
            if (survive && overlap_too_big(box, kept_list[k], live_thr)) survive = 1'b0;
        v.box_index  = c.prior;
        v.keep       = 1'b0;
        v.list_full  = 1'b0;
        v.class_done = c.last;
        if (survive && kept_list.size() >= MAX_KEPT) begin
            v.list_full = 1'b1;
        end else if (survive) begin
            v.keep = 1'b1;
            kept_list.insert(kept_list.size(), box);
            if (eta_reg < ONE_Q16 && live_thr > HALF_Q16)
                live_thr = 17'((64'(live_thr) * eta_reg) >> 16);
        end
        if (c.last) begin
            kept_list.delete();
            live_thr = thr_reg;
        end
        return v;
    endfunction

    task automatic check_field(input string what, input logic [15:0] want_v,
                               input logic [15:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want_v, got_v);
            fail_count++;
        end
    endtask

    // request driver
    always @(negedge i_clk) begin : feed_boxes
        logic nxt_valid;
        nxt_valid = s_tvalid;
        if (i_rst_n) begin
            if (s_tvalid && req_taken) nxt_valid = 1'b0;
            if (!nxt_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (box_stream_q.size() > 0) begin
                    sent_cand = box_stream_q.pop_front();
                    s_tdata <= {sent_cand.y1, sent_cand.x1, sent_cand.y0, sent_cand.x0,
                                sent_cand.prior};
                    s_tlast <= sent_cand.last;
                    nxt_valid = 1'b1;
                    if ($urandom_range(0, 31) == 0) send_calm = !send_calm;
                    send_gap = send_calm ? 0 : $urandom_range(0, 13);
                end
            end
        end
        s_tvalid <= nxt_valid;
    end

    // result backpressure
    always @(negedge i_clk) begin : stall_results
        logic nxt_ready;
        nxt_ready = m_tready;
        if (i_rst_n) begin
            if (m_tready && res_taken) begin
                if ($urandom_range(0, 31) == 0) recv_calm = !recv_calm;
                recv_wait = recv_calm ? 0 : $urandom_range(0, 13);
                nxt_ready = (recv_wait == 0);
            end else if (!m_tready && o_m_axis_tvalid) begin
                if (recv_wait > 0) recv_wait--;
                nxt_ready = (recv_wait == 0);
            end
        end
        m_tready <= nxt_ready;
    end

    // monitor and scoreboard
    always @(posedge i_clk) begin : score_results
        t_verdict want;
        req_taken <= s_tvalid && o_s_axis_tready;
        res_taken <= o_m_axis_tvalid && m_tready;
        if (i_rst_n && s_tvalid && o_s_axis_tready)
            verdict_q.insert(verdict_q.size(), judge_candidate(sent_cand));
        if (i_rst_n && o_m_axis_tvalid && m_tready) begin
            n_results++;
            if (verdict_q.size() == 0) begin
                $display("%0t: result with no request pending, box_index %0d",
                         $time, o_m_axis_tdata);
                fail_count++;
            end else begin
                want = verdict_q.pop_front();
                check_field("box_index", want.box_index, o_m_axis_tdata);
                check_field("keep", 16'(want.keep), 16'(o_m_axis_tuser[0]));
                check_field("list_full", 16'(want.list_full), 16'(o_m_axis_tuser[1]));
                check_field("class_done", 16'(want.class_done), 16'(o_m_axis_tlast));
            end
            if (o_m_axis_tuser[0]) n_kept++;
            else if (o_m_axis_tuser[1]) n_full++;
            else n_supp++;
            if (o_m_axis_tlast) n_classes++;
        end
    end

    task automatic queue_cand(input t_cand c);
        box_stream_q.insert(box_stream_q.size(), c);
        n_boxes++;
    endtask

    task automatic add_box(input int idx, input int x0, input int y0, input int x1,
                           input int y1, input bit last);
        t_cand c;
        c.prior = 16'(idx);
        c.x0    = 16'(x0);
        c.y0    = 16'(y0);
        c.x1    = 16'(x1);
        c.y1    = 16'(y1);
        c.last  = last;
        queue_cand(c);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [16:0] value);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == REG_NMS_THRESHOLD) thr_reg = value;
        else eta_reg = value;
        n_writes++;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // holds the sender off until every outstanding result has come back
    task automatic drain_block();
        while (n_results < n_boxes)
            @(negedge i_clk);
        repeat (3) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    function automatic t_cand make_box(input int cx, input int cy, input bit last);
        t_cand c;
        int    hw;
        int    hh;
        int    jx;
        int    jy;
        logic signed [15:0] t;
        c.prior = 16'($urandom);
        c.last  = last;
        if ($urandom_range(0, 9) == 0) begin
            c.x0 = 16'($urandom);
            c.y0 = 16'($urandom);
            c.x1 = 16'($urandom);
            c.y1 = 16'($urandom);
            return c;
        end
        hw = $urandom_range(1, 3000);
        hh = $urandom_range(1, 3000);
        jx = int'($urandom_range(0, hw)) - hw / 2;
        jy = int'($urandom_range(0, hh)) - hh / 2;
        c.x0 = 16'(cx + jx - hw);
        c.x1 = 16'(cx + jx + hw);
        c.y0 = 16'(cy + jy - hh);
        c.y1 = 16'(cy + jy + hh);
        if ($urandom_range(0, 15) == 0) begin
            t    = c.x0;
            c.x0 = c.x1;
            c.x1 = t;
        end
        return c;
    endfunction

    task automatic fill_classes(input int n_items);
        int left;
        int len;
        int n_centers;
        int k;
        int cx[4];
        int cy[4];
        int pick;
        bit last;
        left = n_items;
        while (left > 0) begin
            len = $urandom_range(1, 24);
            if (len > left) len = left;
            n_centers = $urandom_range(1, 4);
            for (k = 0; k < 4; k++) begin
                cx[k] = int'($urandom_range(0, 56000)) - 28000;
                cy[k] = int'($urandom_range(0, 56000)) - 28000;
            end
            for (k = 0; k < len; k++) begin
                if (k == len - 1) last = ($urandom_range(0, 7) != 0);
                else last = ($urandom_range(0, 49) == 0);
                pick = $urandom_range(0, n_centers - 1);
                queue_cand(make_box(cx[pick], cy[pick], last));
            end
            left -= len;
        end
    endtask

    function automatic logic [16:0] pick_q16(input int usual_lo, input int usual_hi);
        case ($urandom_range(0, 9))
            0: return 17'd0;
            1: return HALF_Q16;
            2: return ONE_Q16;
            3: return 17'h1FFFF;
            4: return 17'($urandom_range(0, 131071));
            default: return 17'($urandom_range(usual_lo, usual_hi));
        endcase
    endfunction

    initial begin : stimulus
        int    i;
        int    j;
        int    base_x;
        int    base_y;
        t_cand grid_copy;
        t_cand c;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default threshold, no decay
        add_box(0, 0, 0, 4096, 4096, 1'b0);
        add_box(1, 0, 0, 4096, 4096, 1'b0);              // identical
        add_box(2, 4096, 0, 8192, 4096, 1'b0);           // shares an edge
        add_box(3, 12288, 12288, 16384, 16384, 1'b0);    // apart
        add_box(4, 200, 300, 100, 500, 1'b0);            // inverted, zero area
        add_box(5, -32768, -32768, 32767, 32767, 1'b0);  // whole range
        add_box(6, -32768, -32768, 32767, 32767, 1'b0);
        add_box(65535, 0, 0, 4096, 8192, 1'b1);          // IoU 0.5 above 0.45
        drain_block();

        // threshold 1.0 decays once to 0.5, then IoU exactly 0.5 survives
        write_reg(REG_NMS_THRESHOLD, ONE_Q16);
        write_reg(REG_ETA, HALF_Q16);
        add_box(10, 0, 0, 8192, 4096, 1'b0);
        add_box(11, 0, 0, 4096, 4096, 1'b0);
        add_box(12, 0, 0, 8192, 4096, 1'b0);
        add_box(13, -4096, -4096, -1, -1, 1'b1);
        drain_block();

        // threshold above one with eta zero collapses to zero after a keep
        write_reg(REG_NMS_THRESHOLD, 17'h1FFFF);
        write_reg(REG_ETA, 17'd0);
        add_box(20, 1000, 1000, 3000, 3000, 1'b0);
        add_box(21, 1000, 1000, 3000, 3000, 1'b0);
        add_box(22, 5000, 5000, 6000, 6000, 1'b0);
        add_box(23, 5999, 5999, 7000, 7000, 1'b1);
        drain_block();

        write_reg(REG_NMS_THRESHOLD, 17'd32769);
        write_reg(REG_ETA, 17'd65535);
        add_box(30, 0, 0, 4096, 4096, 1'b0);
        add_box(31, 0, 0, 4096, 4096, 1'b0);
        add_box(32, 0, 0, 4096, 8192, 1'b1);
        drain_block();

        // fill the kept list with disjoint boxes, then overflow it
        write_reg(REG_NMS_THRESHOLD, THR_RESET);
        write_reg(REG_ETA, 17'h1FFFF);
        for (i = 0; i < 16; i++) begin
            for (j = 0; j < 16; j++) begin
                base_x  = -32768 + 4096 * i;
                base_y  = -32768 + 4096 * j;
                c.prior = 16'($urandom);
                c.x0    = 16'(base_x + int'($urandom_range(0, 1500)));
                c.x1    = 16'(base_x + int'($urandom_range(2500, 4095)));
                c.y0    = 16'(base_y + int'($urandom_range(0, 1500)));
                c.y1    = 16'(base_y + int'($urandom_range(2500, 4095)));
                c.last  = 1'b0;
                if (i == 7 && j == 9) grid_copy = c;
                queue_cand(c);
            end
        end
        add_box($urandom, 300, 300, 100, 900, 1'b0);
        add_box($urandom, -5000, 7000, -5000, 9000, 1'b0);
        grid_copy.prior = 16'($urandom);
        queue_cand(grid_copy);
        add_box($urandom, -32768, -32768, 32767, 32767, 1'b0);
        add_box($urandom, 20000, 20000, 10000, 10000, 1'b1);
        drain_block();

        // random phases with a new setting each time
        while (n_boxes < 1650) begin
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_NMS_THRESHOLD, pick_q16(16000, 50000));
            if ($urandom_range(0, 1) != 0)
                write_reg(REG_ETA, pick_q16(45000, 65536));
            fill_classes($urandom_range(40, 110));
            drain_block();
        end

        repeat (20) @(posedge i_clk);
        $display("ran %0d boxes over %0d closed classes with %0d register writes",
                 n_boxes, n_classes, n_writes);
        $display("verdicts: %0d kept, %0d suppressed, %0d dropped on a full list",
                 n_kept, n_supp, n_full);
        if (fail_count == 0) begin
            $display("greedy_box_nms regression: pass");
        end else begin
            $display("greedy_box_nms regression: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #150_000_000;
        $display("%0t: timed out with %0d results outstanding", $time, verdict_q.size());
        $display("greedy_box_nms regression: fail");
        $finish;
    end

endmodule
